FILE: rtl/http_header_line_parser_assert.svh
// Assertion macros for the HTTP header line parser.
// Used by the top level; no other dependencies.
`ifndef HTTP_HEADER_LINE_PARSER_ASSERT_SVH
`define HTTP_HEADER_LINE_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define HHLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define HHLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HHLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HHLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/hhlp_pkg.sv
// Shared types and constants for the HTTP header line parser.
// No dependencies.
`timescale 1ns / 1ps

package hhlp_pkg;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_END        = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // status line prefix
    localparam logic [7:0] HTTP_WORD [4] = '{8'h48, 8'h54, 8'h54, 8'h50};
    localparam logic [2:0] PREFIX_FULL   = 3'd4;
    localparam logic [2:0] PREFIX_BROKEN = 3'd5;

    typedef struct packed {
        logic is_nul;
        logic is_cr;
        logic is_lf;
        logic is_sp;
        logic is_colon;
        logic is_slash;
        logic is_name;
    } t_byte_class;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [11:0] name_start;
        logic [11:0] name_length;
        logic [11:0] value_start;
        logic [11:0] value_length;
        logic [12:0] consumed;
    } t_result;

endpackage

FILE: rtl/hhlp_byte_class.sv
// Byte classifier for the header line parser.
// Depends on hhlp_pkg.
`timescale 1ns / 1ps

module hhlp_byte_class
    import hhlp_pkg::*;
(
    input  logic [7:0]  i_byte,
    input  logic        i_allow_us,
    output t_byte_class o_class
);

    logic is_lower;
    logic is_upper;
    logic is_digit;

    assign is_lower = (i_byte >= 8'h61) && (i_byte <= 8'h7A);
    assign is_upper = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);

    always_comb begin
        o_class.is_nul   = (i_byte == CH_NUL);
        o_class.is_cr    = (i_byte == CH_CR);
        o_class.is_lf    = (i_byte == CH_LF);
        o_class.is_sp    = (i_byte == CH_SP);
        o_class.is_colon = (i_byte == CH_COLON);
        o_class.is_slash = (i_byte == CH_SLASH);
        o_class.is_name  = is_lower || is_upper || is_digit || (i_byte == CH_DASH) ||
                           ((i_byte == CH_UNDER) && i_allow_us);
    end

endmodule

FILE: rtl/hhlp_core.sv
// Parse state registers and per-byte step logic of the header line parser.
// Depends on hhlp_pkg and hhlp_byte_class.
`timescale 1ns / 1ps

module hhlp_core
    import hhlp_pkg::*;
#(
    parameter int MAX_LINE = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_allow_us,
    output t_result    o_result
);

    localparam int IDX_W = $clog2(MAX_LINE);
    localparam int POS_W = $clog2(MAX_LINE + 1);

    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_NAME      = 3'd1;
    localparam logic [2:0] PH_SP_BEFORE = 3'd2;
    localparam logic [2:0] PH_VALUE     = 3'd3;
    localparam logic [2:0] PH_SP_AFTER  = 3'd4;
    localparam logic [2:0] PH_SKIP      = 3'd5;
    localparam logic [2:0] PH_CR_SEEN   = 3'd6;
    localparam logic [2:0] PH_END_CR    = 3'd7;

    logic [2:0]       r_phase,  n_phase;
    logic [POS_W-1:0] r_pos;
    logic [IDX_W-1:0] r_nb,     n_nb;
    logic [IDX_W-1:0] r_nf,     n_nf;
    logic [IDX_W-1:0] r_vb,     n_vb;
    logic [IDX_W-1:0] r_vf,     n_vf;
    logic [2:0]       r_prefix, n_prefix;

    t_byte_class      cls;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos_nx;
    logic             line_end;
    logic             done;
    logic             with_fields;
    logic             cons_en;
    logic [2:0]       status;
    logic [IDX_W-1:0] name_len;
    logic [IDX_W-1:0] value_len;
    logic [IDX_W+11:0] ext_nb;
    logic [IDX_W+11:0] ext_nl;
    logic [IDX_W+11:0] ext_vb;
    logic [IDX_W+11:0] ext_vl;
    logic [POS_W+12:0] ext_cons;

    hhlp_byte_class u_class (
        .i_byte     (i_byte),
        .i_allow_us (i_allow_us),
        .o_class    (cls)
    );

    // position never reaches MAX_LINE at the start of a step
    assign idx    = r_pos[IDX_W-1:0];
    assign pos_nx = r_pos + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_nb        = r_nb;
        n_nf        = r_nf;
        n_vb        = r_vb;
        n_vf        = r_vf;
        n_prefix    = r_prefix;
        line_end    = 1'b0;
        done        = 1'b0;
        with_fields = 1'b0;
        cons_en     = 1'b0;
        status      = ST_OK;

        if (cls.is_nul) begin
            done   = 1'b1;
            status = ST_INCOMPLETE;
        end else begin
            case (r_phase)
                PH_START: begin
                    n_nb = idx;
                    n_vb = idx;
                    if (cls.is_cr) begin
                        n_vf    = idx;
                        n_phase = PH_END_CR;
                    end else if (cls.is_lf) begin
                        n_vf     = idx;
                        line_end = 1'b1;
                    end else if (cls.is_name) begin
                        n_phase  = PH_NAME;
                        n_prefix = (i_byte == HTTP_WORD[0]) ? 3'd1 : PREFIX_BROKEN;
                    end else begin
                        done   = 1'b1;
                        status = ST_INVALID;
                    end
                end
                PH_NAME: begin
                    if (cls.is_name) begin
                        if (r_prefix < PREFIX_FULL) begin
                            n_prefix = (i_byte == HTTP_WORD[r_prefix[1:0]]) ?
                                       r_prefix + 3'd1 : PREFIX_BROKEN;
                        end
                    end else if (cls.is_colon) begin
                        n_nf    = idx;
                        n_phase = PH_SP_BEFORE;
                    end else if (cls.is_cr) begin
                        n_nf    = idx;
                        n_vb    = idx;
                        n_vf    = idx;
                        n_phase = PH_CR_SEEN;
                    end else if (cls.is_lf) begin
                        n_nf     = idx;
                        n_vb     = idx;
                        n_vf     = idx;
                        line_end = 1'b1;
                    end else if (cls.is_slash && (r_prefix == PREFIX_FULL)) begin
                        n_phase = PH_SKIP;
                    end else begin
                        done   = 1'b1;
                        status = ST_INVALID;
                    end
                end
                PH_SP_BEFORE: begin
                    if (cls.is_sp) begin
                        n_phase = r_phase;
                    end else if (cls.is_cr) begin
                        n_vb    = idx;
                        n_vf    = idx;
                        n_phase = PH_CR_SEEN;
                    end else if (cls.is_lf) begin
                        n_vb     = idx;
                        n_vf     = idx;
                        line_end = 1'b1;
                    end else begin
                        n_vb    = idx;
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (cls.is_sp) begin
                        n_vf    = idx;
                        n_phase = PH_SP_AFTER;
                    end else if (cls.is_cr) begin
                        n_vf    = idx;
                        n_phase = PH_CR_SEEN;
                    end else if (cls.is_lf) begin
                        n_vf     = idx;
                        line_end = 1'b1;
                    end
                end
                PH_SP_AFTER: begin
                    if (cls.is_cr) begin
                        n_phase = PH_CR_SEEN;
                    end else if (cls.is_lf) begin
                        line_end = 1'b1;
                    end else if (!cls.is_sp) begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_SKIP: begin
                    if (cls.is_lf) begin
                        n_phase = PH_START;
                    end
                end
                PH_CR_SEEN: begin
                    if (cls.is_lf) begin
                        line_end = 1'b1;
                    end else if (!cls.is_cr) begin
                        done   = 1'b1;
                        status = ST_INVALID;
                    end
                end
                default: begin
                    // CR seen at line start
                    done = 1'b1;
                    if (cls.is_lf) begin
                        status  = ST_END;
                        cons_en = 1'b1;
                    end else begin
                        status = ST_INVALID;
                    end
                end
            endcase
        end

        if (line_end) begin
            done = 1'b1;
            if ((n_nf <= n_nb) || (n_vf <= n_vb)) begin
                status = ST_INVALID;
            end else begin
                status      = ST_OK;
                with_fields = 1'b1;
                cons_en     = 1'b1;
            end
        end else if (!done) begin
            if (pos_nx == POS_W'(MAX_LINE)) begin
                done   = 1'b1;
                status = ST_TOO_LONG;
            end else if (i_last) begin
                done   = 1'b1;
                status = ST_INCOMPLETE;
            end
        end
    end

    assign name_len  = n_nf - n_nb;
    assign value_len = n_vf - n_vb;
    assign ext_nb    = {12'd0, n_nb};
    assign ext_nl    = {12'd0, name_len};
    assign ext_vb    = {12'd0, n_vb};
    assign ext_vl    = {12'd0, value_len};
    assign ext_cons  = {13'd0, pos_nx};

    always_comb begin
        o_result.valid        = i_step && done;
        o_result.status       = status;
        o_result.name_start   = with_fields ? ext_nb[11:0] : 12'd0;
        o_result.name_length  = with_fields ? ext_nl[11:0] : 12'd0;
        o_result.value_start  = with_fields ? ext_vb[11:0] : 12'd0;
        o_result.value_length = with_fields ? ext_vl[11:0] : 12'd0;
        o_result.consumed     = cons_en ? ext_cons[12:0] : 13'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_pos    <= '0;
            r_nb     <= '0;
            r_nf     <= '0;
            r_vb     <= '0;
            r_vf     <= '0;
            r_prefix <= 3'd0;
        end else if (i_step) begin
            if (done) begin
                r_phase  <= PH_START;
                r_pos    <= '0;
                r_nb     <= '0;
                r_nf     <= '0;
                r_vb     <= '0;
                r_vf     <= '0;
                r_prefix <= 3'd0;
            end else begin
                r_phase  <= n_phase;
                r_pos    <= pos_nx;
                r_nb     <= n_nb;
                r_nf     <= n_nf;
                r_vb     <= n_vb;
                r_vf     <= n_vf;
                r_prefix <= n_prefix;
            end
        end
    end

endmodule

FILE: rtl/http_header_line_parser.sv
// The last byte of a scan is registered at the input, its result at the output.
// Throughput: one byte per cycle while the output side is not stalled.
// An input register and an output register separate the two channels.
// Reset (synchronous, active low) clears the scan state, both stage valids and
// allow_underscore; no clearing pass is needed.
`timescale 1ns / 1ps

`include "http_header_line_parser_assert.svh"

module http_header_line_parser
    import hhlp_pkg::*;
#(
    parameter int MAX_LINE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [11:0] o_name_start,
    output logic [11:0] o_name_length,
    output logic [11:0] o_value_start,
    output logic [11:0] o_value_length,
    output logic [12:0] o_consumed
);

    logic       r_allow_us;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       advance;

    // input stage moves on whenever the output register is free or draining
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_us <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_allow_us <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_buffer_last;
        end
    end

    hhlp_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_allow_us (r_allow_us),
        .o_result   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_res.valid) begin
            r_out <= step_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_name_start   = r_out.name_start;
    assign o_name_length  = r_out.name_length;
    assign o_value_start  = r_out.value_start;
    assign o_value_length = r_out.value_length;
    assign o_consumed     = r_out.consumed;

    `HHLP_ASSERT_IMPL(a_stall_needs_item, i_clk, i_rst_n, o_stall, r_in_valid, "stall with empty input stage")
    `HHLP_ASSERT_IMPL(a_fields_only_ok, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_name_start == 12'd0) && (o_name_length == 12'd0) && (o_value_start == 12'd0) && (o_value_length == 12'd0), "offsets on non-ok result")
    `HHLP_ASSERT_IMPL(a_consumed_only_line, i_clk, i_rst_n, o_valid && (o_status != ST_OK) && (o_status != ST_END), o_consumed == 13'd0, "consumed on failed scan")
    `HHLP_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, step_res.valid, o_valid, "step result not registered")

endmodule

FILE: bench/tb_http_header_line_parser.sv
// Self-checking testbench for http_header_line_parser: byte stream in, one result per scan.
// Depends on hhlp_pkg (status codes, character codes, result struct) and the parser RTL.
`timescale 1ns / 1ps

module tb_http_header_line_parser;
    import hhlp_pkg::*;

    localparam int LINE_MAX    = 4096;
    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [2:0] {
        AT_LINE_START,
        IN_NAME,
        BEFORE_VALUE,
        IN_VALUE,
        AFTER_VALUE,
        IN_STATUS_LINE,
        AFTER_CR,
        BLANK_CR
    } t_line_phase;

    // Tracks one header scan byte by byte and keeps the results it predicts.
    class header_line_tracker;
        t_line_phase phase;
        int unsigned pos;
        int unsigned name_b;
        int unsigned name_f;
        int unsigned val_b;
        int unsigned val_f;
        logic [2:0]  http_match;
        bit          allow_us;
        t_result     expected_lines[$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            allow_us     = 1'b0;
            errors       = 0;
            results_seen = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            phase      = AT_LINE_START;
            pos        = 0;
            name_b     = 0;
            name_f     = 0;
            val_b      = 0;
            val_f      = 0;
            http_match = '0;
        endfunction

        function bit is_name_char(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                   (b >= "0" && b <= "9") || b == CH_DASH;
        endfunction

        function void close_scan(logic [2:0] st, int unsigned cons, bit with_fields);
            t_result     r;
            int unsigned diff;
            r        = '0;
            r.valid  = 1'b1;
            r.status = st;
            if (with_fields) begin
                r.name_start     = name_b[11:0];
                diff             = name_f - name_b;
                r.name_length    = diff[11:0];
                r.value_start    = val_b[11:0];
                diff             = val_f - val_b;
                r.value_length   = diff[11:0];
            end
            r.consumed = cons[12:0];
            expected_lines.insert(expected_lines.size(), r);
            restart_scan();
        endfunction

        function void line_end(int unsigned idx);
            if (name_f <= name_b || val_f <= val_b)
                close_scan(ST_INVALID, 0, 1'b0);
            else
                close_scan(ST_OK, idx + 1, 1'b1);
        endfunction

        // Predict the effect of one accepted byte.
        function void take_byte(logic [7:0] b, logic last);
            int unsigned idx;
            bit          name_ch;
            idx     = pos;
            pos     = pos + 1;
            name_ch = is_name_char(b) || (b == CH_UNDER && allow_us);
            if (b == CH_NUL) begin
                close_scan(ST_INCOMPLETE, 0, 1'b0);
                return;
            end
            case (phase)
                AT_LINE_START: begin
                    name_b = idx;
                    val_b  = idx;
                    if (b == CH_CR) begin
                        val_f = idx;
                        phase = BLANK_CR;
                    end else if (b == CH_LF) begin
                        val_f = idx;
                        line_end(idx);
                        return;
                    end else if (name_ch) begin
                        phase      = IN_NAME;
                        http_match = (b == HTTP_WORD[0]) ? 3'd1 : PREFIX_BROKEN;
                    end else begin
                        close_scan(ST_INVALID, 0, 1'b0);
                        return;
                    end
                end
                IN_NAME: begin
                    if (name_ch) begin
                        if (http_match < PREFIX_FULL)
                            http_match = (b == HTTP_WORD[http_match[1:0]]) ?
                                         http_match + 3'd1 : PREFIX_BROKEN;
                    end else if (b == CH_COLON) begin
                        name_f = idx;
                        phase  = BEFORE_VALUE;
                    end else if (b == CH_CR) begin
                        name_f = idx;
                        val_b  = idx;
                        val_f  = idx;
                        phase  = AFTER_CR;
                    end else if (b == CH_LF) begin
                        name_f = idx;
                        val_b  = idx;
                        val_f  = idx;
                        line_end(idx);
                        return;
                    end else if (b == CH_SLASH && http_match == PREFIX_FULL) begin
                        phase = IN_STATUS_LINE;
                    end else begin
                        close_scan(ST_INVALID, 0, 1'b0);
                        return;
                    end
                end
                BEFORE_VALUE: begin
                    if (b == CH_CR) begin
                        val_b = idx;
                        val_f = idx;
                        phase = AFTER_CR;
                    end else if (b == CH_LF) begin
                        val_b = idx;
                        val_f = idx;
                        line_end(idx);
                        return;
                    end else if (b != CH_SP) begin
                        val_b = idx;
                        phase = IN_VALUE;
                    end
                end
                IN_VALUE: begin
                    if (b == CH_SP) begin
                        val_f = idx;
                        phase = AFTER_VALUE;
                    end else if (b == CH_CR) begin
                        val_f = idx;
                        phase = AFTER_CR;
                    end else if (b == CH_LF) begin
                        val_f = idx;
                        line_end(idx);
                        return;
                    end
                end
                AFTER_VALUE: begin
                    // value end stays at the first trailing space unless text resumes
                    if (b == CH_CR) begin
                        phase = AFTER_CR;
                    end else if (b == CH_LF) begin
                        line_end(idx);
                        return;
                    end else if (b != CH_SP) begin
                        phase = IN_VALUE;
                    end
                end
                IN_STATUS_LINE: begin
                    if (b == CH_LF)
                        phase = AT_LINE_START;
                end
                AFTER_CR: begin
                    if (b == CH_LF) begin
                        line_end(idx);
                        return;
                    end
                    if (b != CH_CR) begin
                        close_scan(ST_INVALID, 0, 1'b0);
                        return;
                    end
                end
                default: begin
                    if (b == CH_LF)
                        close_scan(ST_END, idx + 1, 1'b0);
                    else
                        close_scan(ST_INVALID, 0, 1'b0);
                    return;
                end
            endcase
            // line length limit wins over buffer end
            if (pos >= LINE_MAX)
                close_scan(ST_TOO_LONG, 0, 1'b0);
            else if (last)
                close_scan(ST_INCOMPLETE, 0, 1'b0);
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task cmp_field(string field, logic [12:0] got, logic [12:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 results_seen, field, got, want));
        endtask

        task check_result(logic [2:0] st, logic [11:0] ns, logic [11:0] nl,
                          logic [11:0] vs, logic [11:0] vl, logic [12:0] cons);
            t_result want;
            if (expected_lines.size() == 0) begin
                report($sformatf("result %0d arrived with none pending (status %0d)",
                                 results_seen, st));
                results_seen++;
                return;
            end
            want = expected_lines.pop_front();
            cmp_field("status", {10'd0, st}, {10'd0, want.status});
            cmp_field("name_start", {1'b0, ns}, {1'b0, want.name_start});
            cmp_field("name_length", {1'b0, nl}, {1'b0, want.name_length});
            cmp_field("value_start", {1'b0, vs}, {1'b0, want.value_start});
            cmp_field("value_length", {1'b0, vl}, {1'b0, want.value_length});
            cmp_field("consumed", cons, want.consumed);
            results_seen++;
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_data_byte   = 8'd0;
    logic        i_buffer_last = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [11:0] o_name_start;
    logic [11:0] o_name_length;
    logic [11:0] o_value_start;
    logic [11:0] o_value_length;
    logic [12:0] o_consumed;

    header_line_tracker tracker;
    logic [7:0]         line_q[$];
    int                 sent_bytes    = 0;
    int                 src_idle_pct  = 8;
    int                 rcv_stall_pct = 56;
    int                 quiet_cycles  = 0;

    http_header_line_parser #(
        .MAX_LINE(LINE_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_buffer_last (i_buffer_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_name_start  (o_name_start),
        .o_name_length (o_name_length),
        .o_value_start (o_value_start),
        .o_value_length(o_value_length),
        .o_consumed    (o_consumed)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result(o_status, o_name_start, o_name_length,
                                 o_value_start, o_value_length, o_consumed);
    end

    // watchdog: consecutive cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_buffer_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_byte(b, last);
    endtask

    task automatic send_line(input bit close_buffer, input int stray_last_pct);
        int n;
        n = line_q.size();
        for (int i = 0; i < n; i++)
            send_byte(line_q[i], (close_buffer && i == n - 1) ||
                                 ($urandom_range(99) < stray_last_pct));
        sent_bytes += n;
        line_q.delete();
    endtask

    // allow_underscore may change only with nothing in flight
    task automatic write_underscore(input bit v);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.allow_us = v;
    endtask

    task automatic add_byte(input logic [7:0] b);
        line_q.insert(line_q.size(), b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic put_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    function automatic logic [7:0] rand_value_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(255, 1));
        while (v == CH_CR || v == CH_LF || v == CH_SP);
        return v;
    endfunction

    task automatic put_name();
        int n;
        n = $urandom_range(10, 1);
        repeat (n) begin
            case ($urandom_range(3))
                0: add_byte(8'("A" + $urandom_range(25)));
                1: add_byte(8'("a" + $urandom_range(25)));
                2: add_byte(8'("0" + $urandom_range(9)));
                default: add_byte(($urandom_range(4) == 0) ? CH_UNDER : CH_DASH);
            endcase
        end
    endtask

    task automatic put_value(input int n);
        for (int i = 0; i < n; i++)
            add_byte((i > 0 && i < n - 1 && $urandom_range(9) == 0) ?
                     CH_SP : rand_value_byte());
    endtask

    task automatic put_line_end();
        case ($urandom_range(5))
            3: add_byte(CH_LF);
            4: begin
                add_byte(CH_CR);
                put_crlf();
            end
            5: begin
                add_byte(CH_CR);
                add_byte(CH_CR);
                put_crlf();
            end
            default: put_crlf();
        endcase
    endtask

    task automatic gen_header();
        put_name();
        add_byte(CH_COLON);
        repeat ($urandom_range(2)) add_byte(CH_SP);
        put_value(($urandom_range(15) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1));
        repeat ($urandom_range(2)) add_byte(CH_SP);
        put_line_end();
    endtask

    task automatic gen_malformed();
        case ($urandom_range(5))
            0: begin
                // empty value
                put_name();
                add_byte(CH_COLON);
                repeat ($urandom_range(2)) add_byte(CH_SP);
                put_line_end();
            end
            1: begin
                // no colon
                put_name();
                put_line_end();
            end
            2: begin
                add_byte(CH_COLON);
                put_value(2);
                add_byte(CH_LF);
            end
            3: add_byte(CH_LF);
            4: begin
                add_byte(CH_CR);
                add_byte(rand_value_byte());
            end
            default: begin
                // near misses of a status line; HTTPS still counts as one
                case ($urandom_range(3))
                    0: put_str("HTTp/1 ");
                    1: put_str("HTP/1 ");
                    2: put_str("Http/1 ");
                    default: put_str("HTTPS/1 ");
                endcase
                add_byte(CH_LF);
            end
        endcase
    endtask

    task automatic gen_random_line();
        int kind;
        kind = $urandom_range(99);
        if (kind < 60) begin
            gen_header();
        end else if (kind < 68) begin
            put_crlf();
        end else if (kind < 78) begin
            put_str("HTTP/");
            put_value($urandom_range(10, 1));
            put_line_end();
            if ($urandom_range(2) == 0)
                put_crlf();
            else
                gen_header();
        end else if (kind < 90) begin
            gen_malformed();
        end else begin
            repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 6)
            line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(99) < 2)
            line_q[$urandom_range(line_q.size() - 1)] = CH_NUL;
    endtask

    task automatic run_phase(input bit us, input int src_pct, input int rcv_pct, input int n);
        int goal;
        write_underscore(us);
        src_idle_pct  = src_pct;
        rcv_stall_pct = rcv_pct;
        goal = sent_bytes + n;
        while (sent_bytes < goal) begin
            gen_random_line();
            send_line($urandom_range(99) < 4, 1);
        end
    endtask

    initial begin
        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_underscore(1'b0);

        put_str("H: x ");          // trailing space trimmed
        put_crlf();
        send_line(1'b0, 0);
        put_crlf();                // end of headers
        send_line(1'b0, 0);
        add_byte(CH_LF);           // bare LF at line start
        send_line(1'b0, 0);
        put_str("a_b:1");          // underscore rejected while disabled
        add_byte(CH_LF);
        send_line(1'b0, 0);
        add_byte(CH_NUL);
        send_line(1'b0, 0);
        add_byte(8'hFF);
        send_line(1'b0, 0);
        put_str("HTTP/1");         // status line skipped, offsets keep counting
        add_byte(CH_LF);
        put_str("A:1");
        put_crlf();
        send_line(1'b0, 0);
        put_str("Ab");             // buffer ends mid-name
        send_line(1'b1, 0);

        run_phase(1'b1, 8, 56, 255);
        run_phase(1'b0, 56, 8, 255);
        run_phase(1'b1, 0, 0, 255);
        run_phase(1'b0, 0, 0, 255);

        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
